[design/gvr_pkg.sv]
// Shared types, codes and widths of the gamepad velocity reference block.
`default_nettype none

package gvr_pkg;

  localparam int AXIS_W     = 16;
  localparam int SCALE_W    = 16;
  localparam int WEIGHT_W   = 17;
  localparam int BAND_W     = 16;
  localparam int REF_W      = 21;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;
  localparam int REF_MAX    = 1048575;

  localparam logic [SCALE_W-1:0]  SCALE_RESET  = 16'd4096;
  localparam logic [WEIGHT_W-1:0] WEIGHT_UNITY = 17'd65536;
  localparam logic [BAND_W-1:0]   BAND_RESET   = 16'd262;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCALE_FORWARD = 3'd0,
    REG_SCALE_LATERAL = 3'd1,
    REG_SCALE_TURN    = 3'd2,
    REG_FILTER_WEIGHT = 3'd3,
    REG_DEAD_BAND     = 3'd4
  } cfg_reg_e;

  // Event type bytes
  localparam logic [7:0] KIND_BUTTON = 8'd1;
  localparam logic [7:0] KIND_AXIS   = 8'd2;

  // Control numbers
  localparam logic [7:0] AXIS_NUM_LATERAL = 8'd0;
  localparam logic [7:0] AXIS_NUM_FORWARD = 8'd1;
  localparam logic [7:0] AXIS_NUM_TURN    = 8'd3;
  localparam logic [7:0] BTN_NUM_LAST_PAD = 8'd5;
  localparam logic [7:0] BTN_NUM_SELECT   = 8'd8;
  localparam logic [7:0] BTN_NUM_START    = 8'd9;

  // Positions in the held-button byte
  localparam logic [2:0] BIT_SELECT = 3'd6;
  localparam logic [2:0] BIT_START  = 3'd7;

  typedef enum logic [1:0] {
    CH_FORWARD = 2'd0,
    CH_LATERAL = 2'd1,
    CH_TURN    = 2'd2
  } chan_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_TARGET,
    ST_DIVIDE,
    ST_TARGET,
    ST_MUL_FILTER,
    ST_UPDATE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic  apply_event;
    logic  mul_target;
    logic  div_target;
    logic  make_target;
    logic  mul_filter;
    logic  update_ref;
    logic  load_result;
    chan_e chan;
  } dp_cmd_t;

endpackage

`default_nettype wire

[design/gvr_if.sv]
// Channel interfaces: joystick sample, velocity result and configuration write.
`default_nettype none

interface gvr_sample_if import gvr_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     event_present;
  logic [7:0]               event_kind;
  logic [7:0]               control_number;
  logic signed [AXIS_W-1:0] control_value;

  modport source (output valid, event_present, event_kind, control_number, control_value,
                  input ready);
  modport sink   (input valid, event_present, event_kind, control_number, control_value,
                  output ready);
endinterface

interface gvr_result_if import gvr_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [REF_W-1:0] ref_forward;
  logic signed [REF_W-1:0] ref_lateral;
  logic signed [REF_W-1:0] ref_turn;
  logic [7:0]              button_bits;
  logic                    stop_request;
  logic                    start_request;

  modport source (output valid, ref_forward, ref_lateral, ref_turn, button_bits,
                  stop_request, start_request, input ready);
  modport sink   (input valid, ref_forward, ref_lateral, ref_turn, button_bits,
                  stop_request, start_request, output ready);
endinterface

interface gvr_cfg_if import gvr_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, reg_index, data, input ready);
  modport sink   (input valid, reg_index, data, output ready);
endinterface

`default_nettype wire

[design/gvr_ctrl.sv]
// Sequencer: steps the datapath through the three axes and owns the result valid.
`default_nettype none

module gvr_ctrl import gvr_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    sample_valid,
  output logic    sample_ready,
  output logic    result_valid,
  input  logic    result_ready,
  output dp_cmd_t cmd
);

  state_t state, state_next;
  chan_e  chan, chan_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      chan         <= CH_FORWARD;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      chan  <= chan_next;
      if (cmd.load_result) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next   = state;
    chan_next    = chan;
    cmd          = '0;
    cmd.chan     = chan;
    sample_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        sample_ready = 1'b1;
        if (sample_valid) begin
          cmd.apply_event = 1'b1;
          chan_next       = CH_FORWARD;
          state_next      = ST_MUL_TARGET;
        end
      end
      ST_MUL_TARGET: begin
        cmd.mul_target = 1'b1;
        state_next     = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        cmd.div_target = 1'b1;
        state_next     = ST_TARGET;
      end
      ST_TARGET: begin
        cmd.make_target = 1'b1;
        state_next      = ST_MUL_FILTER;
      end
      ST_MUL_FILTER: begin
        cmd.mul_filter = 1'b1;
        state_next     = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd.update_ref = 1'b1;
        case (chan)
          CH_FORWARD: begin
            chan_next  = CH_LATERAL;
            state_next = ST_MUL_TARGET;
          end
          CH_LATERAL: begin
            chan_next  = CH_TURN;
            state_next = ST_MUL_TARGET;
          end
          default: begin
            state_next = ST_DONE;
          end
        endcase
      end
      ST_DONE: begin
        // hold until the result register is free
        if (!result_valid || result_ready) begin
          cmd.load_result = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[design/gvr_dp.sv]
// Datapath: configuration, event state, target and filter arithmetic, result register.
`default_nettype none

module gvr_dp import gvr_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  dp_cmd_t                  cmd,
  input  logic                     cfg_write,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data,
  input  logic                     event_present,
  input  logic [7:0]               event_kind,
  input  logic [7:0]               control_number,
  input  logic signed [AXIS_W-1:0] control_value,
  output logic signed [REF_W-1:0]  ref_forward,
  output logic signed [REF_W-1:0]  ref_lateral,
  output logic signed [REF_W-1:0]  ref_turn,
  output logic [7:0]               button_bits,
  output logic                     stop_request,
  output logic                     start_request
);

  localparam logic signed [24:0] UPD_MAX = 25'sd1048575;
  localparam logic signed [24:0] UPD_MIN = -25'sd1048575;

  logic [SCALE_W-1:0]  scale_forward, scale_lateral, scale_turn;
  logic [WEIGHT_W-1:0] filter_weight;
  logic [BAND_W-1:0]   dead_band;

  logic signed [AXIS_W-1:0] axis_forward, axis_lateral, axis_turn;
  logic [7:0]               buttons_held;
  logic                     stop_latched, start_latched;
  logic signed [REF_W-1:0]  filt_forward, filt_lateral, filt_turn;

  logic [31:0]             prod_t;
  logic [21:0]             quot;
  logic signed [REF_W-1:0] target;
  logic signed [39:0]      prod_f;

  logic signed [AXIS_W-1:0] axis_sel;
  logic [SCALE_W-1:0]       scale_sel;
  logic signed [REF_W-1:0]  ref_sel;
  logic [7:0]               btn_next;
  logic                     btn_hit;
  logic [2:0]               btn_idx;
  logic [AXIS_W-1:0]        mag;

  logic [35:0]             tx;
  logic [20:0]             ta;
  logic [21:0]             ts;
  logic [6:0]              tc;
  logic [15:0]             tcd;
  logic [21:0]             tq;
  logic [REF_W-1:0]        tq_sat;
  logic [REF_W-1:0]        tq_dz;
  logic signed [REF_W-1:0] target_calc;

  logic [WEIGHT_W-1:0]     w_eff;
  logic signed [21:0]      diff;
  logic signed [39:0]      rsum;
  logic signed [24:0]      upd;
  logic signed [REF_W-1:0] upd_sat;

  always_comb begin
    case (cmd.chan)
      CH_FORWARD: begin
        axis_sel  = axis_forward;
        scale_sel = scale_forward;
        ref_sel   = filt_forward;
      end
      CH_LATERAL: begin
        axis_sel  = axis_lateral;
        scale_sel = scale_lateral;
        ref_sel   = filt_lateral;
      end
      default: begin
        axis_sel  = axis_turn;
        scale_sel = scale_turn;
        ref_sel   = filt_turn;
      end
    endcase
  end

  // button map: pad buttons keep their number, select and start go to the top bits
  always_comb begin
    btn_next = buttons_held;
    btn_hit  = 1'b1;
    btn_idx  = control_number[2:0];
    if (control_number inside {[8'd0:BTN_NUM_LAST_PAD]}) begin
      btn_idx = control_number[2:0];
    end else if (control_number == BTN_NUM_SELECT) begin
      btn_idx = BIT_SELECT;
    end else if (control_number == BTN_NUM_START) begin
      btn_idx = BIT_START;
    end else begin
      btn_hit = 1'b0;
    end
    if (event_present && event_kind == KIND_BUTTON && btn_hit) begin
      btn_next[btn_idx] = (control_value != '0);
    end
  end

  // magnitude; the most negative axis value gives 0x8000
  assign mag = axis_sel[AXIS_W-1] ? (~axis_sel + 16'd1) : axis_sel;

  // divide by 32767 as 2^15 - 1: fold the high part back into the low part twice
  always_comb begin
    tx  = {prod_t, 4'b0000} + 36'd16383;
    ta  = tx[35:15];
    ts  = {1'b0, ta} + {7'd0, tx[14:0]};
    tc  = ts[21:15];
    tcd = {9'd0, tc} + {1'b0, ts[14:0]};
    tq  = {1'b0, ta} + {15'd0, tc} + {21'd0, (tcd >= 16'd32767)};
  end

  // clip, dead band and sign on the registered quotient
  always_comb begin
    tq_sat = (quot > 22'(REF_MAX)) ? REF_W'(REF_MAX) : quot[REF_W-1:0];
    tq_dz  = (tq_sat < {5'd0, dead_band}) ? '0 : tq_sat;
    target_calc = axis_sel[AXIS_W-1] ? $signed(tq_dz) : -$signed(tq_dz);
  end

  always_comb begin
    w_eff   = (filter_weight > WEIGHT_UNITY) ? WEIGHT_UNITY : filter_weight;
    diff    = {target[REF_W-1], target} - {ref_sel[REF_W-1], ref_sel};
    rsum    = prod_f + 40'sd32768;
    upd     = {{4{ref_sel[REF_W-1]}}, ref_sel} + {rsum[39], rsum[39:16]};
    upd_sat = (upd > UPD_MAX) ? UPD_MAX[REF_W-1:0] :
              (upd < UPD_MIN) ? UPD_MIN[REF_W-1:0] : upd[REF_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_forward <= SCALE_RESET;
      scale_lateral <= SCALE_RESET;
      scale_turn    <= SCALE_RESET;
      filter_weight <= WEIGHT_UNITY;
      dead_band     <= BAND_RESET;
      axis_forward  <= '0;
      axis_lateral  <= '0;
      axis_turn     <= '0;
      buttons_held  <= '0;
      stop_latched  <= 1'b0;
      start_latched <= 1'b0;
      filt_forward  <= '0;
      filt_lateral  <= '0;
      filt_turn     <= '0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_SCALE_FORWARD: scale_forward <= cfg_data[SCALE_W-1:0];
          REG_SCALE_LATERAL: scale_lateral <= cfg_data[SCALE_W-1:0];
          REG_SCALE_TURN:    scale_turn    <= cfg_data[SCALE_W-1:0];
          REG_FILTER_WEIGHT: filter_weight <= cfg_data[WEIGHT_W-1:0];
          REG_DEAD_BAND:     dead_band     <= cfg_data[BAND_W-1:0];
          default: ;
        endcase
      end
      if (cmd.apply_event) begin
        buttons_held  <= btn_next;
        stop_latched  <= stop_latched | btn_next[BIT_SELECT];
        start_latched <= start_latched | btn_next[BIT_START];
        if (event_present && event_kind == KIND_AXIS) begin
          case (control_number)
            AXIS_NUM_FORWARD: axis_forward <= control_value;
            AXIS_NUM_LATERAL: axis_lateral <= control_value;
            AXIS_NUM_TURN:    axis_turn    <= control_value;
            default: ;
          endcase
        end
      end
      if (cmd.update_ref) begin
        case (cmd.chan)
          CH_FORWARD: filt_forward <= upd_sat;
          CH_LATERAL: filt_lateral <= upd_sat;
          default:    filt_turn    <= upd_sat;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_target) begin
      prod_t <= {16'd0, mag} * {16'd0, scale_sel};
    end
    if (cmd.div_target) begin
      quot <= tq;
    end
    if (cmd.make_target) begin
      target <= target_calc;
    end
    if (cmd.mul_filter) begin
      prod_f <= 40'($signed({1'b0, w_eff})) * 40'(diff);
    end
    if (cmd.load_result) begin
      ref_forward   <= filt_forward;
      ref_lateral   <= filt_lateral;
      ref_turn      <= filt_turn;
      button_bits   <= buttons_held;
      stop_request  <= stop_latched;
      start_request <= start_latched;
    end
  end

endmodule

`default_nettype wire

[design/gamepad_velocity_reference_core.sv]
// Top level of the gamepad velocity reference block.
//
// One sample transfer carries an optional joystick event; the block applies
// it (button type 1 sets or clears one of eight held bits, axis type 2 stores
// the forward, lateral or yaw position, anything else is dropped) and then
// returns exactly one result transfer holding three Q4.16 velocity
// references, the held buttons and the sticky stop and start requests. Each
// axis becomes a target of |axis| * scale * 16 / 32767, rounded, sign
// opposite to the axis, saturated to +/-1048575 and zeroed inside the dead
// band, then low-pass filtered into its held reference. The event is applied
// at the sample transfer itself; then each of the three axes in turn goes
// through gain multiply, divide, clip and dead band, filter multiply and
// reference update on one shared target multiplier and one shared filter
// multiplier, and the result register is loaded last. The block takes no new
// sample while one is in work; the next sample is taken as soon as
// that register is loaded, so a waiting result stalls the sample side only
// once the following sample has finished as well. Configuration writes are
// always accepted and must be issued only while the block is idle.
`default_nettype none

module gamepad_velocity_reference_core import gvr_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  gvr_sample_if.sink   sample,
  gvr_result_if.source result,
  gvr_cfg_if.sink      cfg
);

  dp_cmd_t cmd;

  // configuration registers never stall
  assign cfg.ready = 1'b1;

  gvr_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample.valid),
    .sample_ready (sample.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .cmd          (cmd)
  );

  gvr_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .cfg_write      (cfg.valid),
    .cfg_index      (cfg.reg_index),
    .cfg_data       (cfg.data),
    .event_present  (sample.event_present),
    .event_kind     (sample.event_kind),
    .control_number (sample.control_number),
    .control_value  (sample.control_value),
    .ref_forward    (result.ref_forward),
    .ref_lateral    (result.ref_lateral),
    .ref_turn       (result.ref_turn),
    .button_bits    (result.button_bits),
    .stop_request   (result.stop_request),
    .start_request  (result.start_request)
  );

endmodule

`default_nettype wire

[design/gvr_checker.sv]
// Port-level checks of the gamepad velocity reference block and their bind.
`default_nettype none

module gvr_checker import gvr_pkg::*; (
  input logic                    clk,
  input logic                    rst,
  input logic                    sample_valid,
  input logic                    sample_ready,
  input logic                    result_valid,
  input logic                    result_ready,
  input logic signed [REF_W-1:0] ref_forward,
  input logic [7:0]              button_bits,
  input logic                    stop_request,
  input logic                    start_request
);

  // one sample at a time: the sample side closes after every transfer
  assert property (@(posedge clk) disable iff (rst)
    sample_valid && sample_ready |=> !sample_ready)
    else $error("sample accepted while previous sample still in work");

  // a held select or start always shows up in its sticky request
  assert property (@(posedge clk) disable iff (rst)
    result_valid && button_bits[BIT_SELECT] |-> stop_request)
    else $error("select held without stop request");

  assert property (@(posedge clk) disable iff (rst)
    result_valid && button_bits[BIT_START] |-> start_request)
    else $error("start held without start request");

  // a stalled result keeps its reference
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(ref_forward))
    else $error("stalled result changed");

endmodule

bind gamepad_velocity_reference_core gvr_checker u_gvr_checker (
  .clk           (clk),
  .rst           (rst),
  .sample_valid  (sample.valid),
  .sample_ready  (sample.ready),
  .result_valid  (result.valid),
  .result_ready  (result.ready),
  .ref_forward   (result.ref_forward),
  .button_bits   (result.button_bits),
  .stop_request  (result.stop_request),
  .start_request (result.start_request)
);

`default_nettype wire

[verif/tb_top.sv]
// Self-checking testbench of the gamepad velocity reference core.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import gvr_pkg::*;

  // Run bounds. The slowest correct run (every transfer meeting the longest
  // gaps on both sides) stays well below a quarter of the cycle limit.
  localparam int     CYCLE_LIMIT      = 1_000_000;
  localparam int     SETTLE_CYCLES    = 20;
  localparam int     RANDOM_PER_PHASE = 130;
  localparam int     HOLD_OFF_CYCLES  = 300;
  localparam longint UNITY            = 65536;

  // Codes used in events that the block has to ignore
  localparam logic [7:0] KIND_INIT_FLAG    = 8'h80;
  localparam logic [7:0] AXIS_NUM_VERTICAL = 8'd2;
  localparam logic [7:0] BTN_NUM_UNMAPPED  = 8'd6;
  localparam logic [7:0] BTN_NUM_CROSS     = 8'd0;

  typedef struct packed {
    logic signed [REF_W-1:0] fwd;
    logic signed [REF_W-1:0] lat;
    logic signed [REF_W-1:0] turn;
    logic [7:0]              buttons;
    logic                    stop;
    logic                    start;
  } velocity_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  gvr_sample_if sample ();
  gvr_result_if result ();
  gvr_cfg_if    cfg ();

  gamepad_velocity_reference_core dut (
    .clk    (clk),
    .rst    (rst),
    .sample (sample),
    .result (result),
    .cfg    (cfg)
  );

  always #4 clk = ~clk;

  // Mirror of the block: gains, filter weight and dead band as last written,
  // raw axes, held buttons, sticky requests and the three held references.
  logic [SCALE_W-1:0]      gain [3];
  logic [WEIGHT_W-1:0]     smooth_weight;
  logic [BAND_W-1:0]       band;
  logic signed [AXIS_W-1:0] axis_pos [3];
  logic [7:0]              held;
  logic                    stop_seen;
  logic                    start_seen;
  logic signed [REF_W-1:0] ref_held [3];

  velocity_t velocity_expected [$];

  bit failed;
  bit steady;       // no idle gaps on either side while set
  int sink_hold;    // long receiver hold-off, counted down by the receiver
  int sink_stall;
  int cycle_count;

  // Gaps: mostly none or short, now and then long.
  function automatic int idle_gap();
    int pick;
    if (steady) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    if (pick < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Velocity target of one axis: |axis| * gain * 16 / 32767 rounded to
  // nearest, clipped, zeroed inside the dead band, sign against the axis.
  function automatic longint axis_target(logic signed [AXIS_W-1:0] pos,
                                         logic [SCALE_W-1:0] g,
                                         logic [BAND_W-1:0] dz);
    longint mag, gl, dl, q;
    mag = longint'(pos);
    if (mag < 0) mag = -mag;
    gl = longint'(g);
    dl = longint'(dz);
    q = (mag * gl * 16 + 16383) / 32767;
    if (q > REF_MAX) q = REF_MAX;
    if (q < dl) q = 0;
    return (pos > 0) ? -q : q;
  endfunction

  // One low-pass step; weights above unity act as unity, round to nearest.
  function automatic logic signed [REF_W-1:0] low_pass(longint target,
                                                       logic signed [REF_W-1:0] prev,
                                                       logic [WEIGHT_W-1:0] weight);
    longint w, p, s;
    w = longint'(weight);
    if (w > UNITY) w = UNITY;
    p = longint'(prev);
    s = (w * target + (UNITY - w) * p + 32768) >>> 16;
    if (s > REF_MAX) s = REF_MAX;
    if (s < -REF_MAX) s = -REF_MAX;
    return s[REF_W-1:0];
  endfunction

  // Apply one sample to the mirror and return the result it must produce.
  function automatic velocity_t next_velocity(logic present, logic [7:0] kind,
                                              logic [7:0] num,
                                              logic signed [AXIS_W-1:0] value);
    velocity_t v;
    int        bit_pos;
    bit_pos = -1;
    if (present && kind == KIND_BUTTON) begin
      if (num <= BTN_NUM_LAST_PAD) bit_pos = int'(num);
      else if (num == BTN_NUM_SELECT) bit_pos = int'(BIT_SELECT);
      else if (num == BTN_NUM_START) bit_pos = int'(BIT_START);
      if (bit_pos >= 0) held[bit_pos] = (value != 0);
    end else if (present && kind == KIND_AXIS) begin
      if (num == AXIS_NUM_FORWARD) axis_pos[CH_FORWARD] = value;
      else if (num == AXIS_NUM_LATERAL) axis_pos[CH_LATERAL] = value;
      else if (num == AXIS_NUM_TURN) axis_pos[CH_TURN] = value;
    end
    if (held[BIT_SELECT]) stop_seen = 1'b1;
    if (held[BIT_START]) start_seen = 1'b1;
    for (int c = 0; c < 3; c++)
      ref_held[c] = low_pass(axis_target(axis_pos[c], gain[c], band), ref_held[c],
                             smooth_weight);
    v.fwd     = ref_held[CH_FORWARD];
    v.lat     = ref_held[CH_LATERAL];
    v.turn    = ref_held[CH_TURN];
    v.buttons = held;
    v.stop    = stop_seen;
    v.start   = start_seen;
    return v;
  endfunction

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failed = 1'b1;
    end
  endfunction

  // Scoreboard: every transfer is observed on the pre-edge values of the
  // handshake. Check the result first, so a sample taken in the same cycle
  // can never be matched against its own result.
  always @(posedge clk) begin : scoreboard
    velocity_t want;
    if (rst) begin
      gain[CH_FORWARD] = SCALE_RESET;
      gain[CH_LATERAL] = SCALE_RESET;
      gain[CH_TURN]    = SCALE_RESET;
      smooth_weight    = WEIGHT_UNITY;
      band             = BAND_RESET;
      held             = '0;
      stop_seen        = 1'b0;
      start_seen       = 1'b0;
      for (int c = 0; c < 3; c++) begin
        axis_pos[c] = '0;
        ref_held[c] = '0;
      end
    end else begin
      if (result.valid && result.ready) begin
        if (velocity_expected.size() == 0) begin
          $error("result transfer with no sample outstanding");
          failed = 1'b1;
        end else begin
          want = velocity_expected.pop_front();
          check_field("ref_forward", want.fwd, result.ref_forward);
          check_field("ref_lateral", want.lat, result.ref_lateral);
          check_field("ref_turn", want.turn, result.ref_turn);
          check_field("button_bits", want.buttons, result.button_bits);
          check_field("stop_request", want.stop, result.stop_request);
          check_field("start_request", want.start, result.start_request);
        end
      end
      if (sample.valid && sample.ready)
        velocity_expected.push_back(next_velocity(sample.event_present, sample.event_kind,
                                                  sample.control_number,
                                                  sample.control_value));
      if (cfg.valid && cfg.ready) begin
        case (cfg_reg_e'(cfg.reg_index))
          REG_SCALE_FORWARD: gain[CH_FORWARD] = cfg.data[SCALE_W-1:0];
          REG_SCALE_LATERAL: gain[CH_LATERAL] = cfg.data[SCALE_W-1:0];
          REG_SCALE_TURN:    gain[CH_TURN]    = cfg.data[SCALE_W-1:0];
          REG_FILTER_WEIGHT: smooth_weight    = cfg.data[WEIGHT_W-1:0];
          REG_DEAD_BAND:     band             = cfg.data[BAND_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Receiver: a commanded hold-off wins over the random stalls.
  initial begin
    result.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (sink_hold > 0) begin
        result.ready <= 1'b0;
        sink_hold--;
      end else if (sink_stall > 0) begin
        result.ready <= 1'b0;
        sink_stall--;
      end else begin
        result.ready <= 1'b1;
        sink_stall = idle_gap();
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Offer one sample and hold it until the transfer. Keep valid high when no
  // gap follows, so back-to-back samples never drop it within one step.
  task automatic send_sample(input logic present, input logic [7:0] kind,
                             input logic [7:0] num, input logic [15:0] value);
    int gap;
    sample.valid          <= 1'b1;
    sample.event_present  <= present;
    sample.event_kind     <= kind;
    sample.control_number <= num;
    sample.control_value  <= value;
    do @(posedge clk); while (!sample.ready);
    gap = idle_gap();
    if (gap > 0) begin
      sample.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Mostly well-formed axis and button events on the mapped controls, with
  // ticks that carry no event and raw noise mixed in.
  task automatic send_random_event();
    logic       present;
    logic [7:0] kind;
    logic [7:0] num;
    logic [15:0] value;
    int         pick;
    present = 1'b1;
    kind    = 8'($urandom);
    num     = 8'($urandom);
    value   = 16'($urandom);
    pick    = $urandom_range(0, 99);
    if (pick < 45) begin
      kind = KIND_AXIS;
      case ($urandom_range(0, 9))
        0, 1, 2: num = AXIS_NUM_FORWARD;
        3, 4, 5: num = AXIS_NUM_LATERAL;
        6, 7, 8: num = AXIS_NUM_TURN;
        default: ;
      endcase
      case ($urandom_range(0, 9))
        0: value = 16'h7FFF;
        1: value = 16'h8000;
        2: value = '0;
        3, 4: begin
          // land around the dead band edge
          value = 16'($urandom_range(0, 600));
          if ($urandom_range(0, 1)) value = -value;
        end
        default: ;
      endcase
    end else if (pick < 75) begin
      kind = KIND_BUTTON;
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: num = 8'($urandom_range(0, BTN_NUM_LAST_PAD));
        6: num = BTN_NUM_SELECT;
        7: num = BTN_NUM_START;
        default: ;
      endcase
      if ($urandom_range(0, 1)) value = '0;
    end else if (pick < 88) begin
      present = 1'b0;
    end
    send_sample(present, kind, num, value);
  endtask

  task automatic run_random(input int count);
    repeat (count) send_random_event();
  endtask

  // Drop valid, let every outstanding result arrive, then let the block
  // settle before anything touches its registers.
  task automatic wait_drained();
    sample.valid <= 1'b0;
    while (velocity_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_transfer(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] data);
    cfg.valid     <= 1'b1;
    cfg.reg_index <= idx;
    cfg.data      <= data;
    do @(posedge clk); while (!cfg.ready);
  endtask

  // Write all five registers back to back, valid held across them.
  task automatic apply_settings(input logic [15:0] sf, input logic [15:0] sl,
                                input logic [15:0] st, input logic [16:0] w,
                                input logic [15:0] db);
    cfg_transfer(REG_SCALE_FORWARD, {1'b0, sf});
    cfg_transfer(REG_SCALE_LATERAL, {1'b0, sl});
    cfg_transfer(REG_SCALE_TURN, {1'b0, st});
    cfg_transfer(REG_FILTER_WEIGHT, w);
    cfg_transfer(REG_DEAD_BAND, {1'b0, db});
    cfg.valid <= 1'b0;
  endtask

  // Reset settings: field extremes, the dead band edge, every mapped and a
  // few unmapped controls, sticky requests, and event kinds to be dropped.
  task automatic test_directed_events();
    send_sample(1'b0, 8'hFF, 8'hFF, 16'hFFFF);
    send_sample(1'b1, KIND_AXIS, AXIS_NUM_FORWARD, 16'h7FFF);
    send_sample(1'b1, KIND_AXIS, AXIS_NUM_FORWARD, 16'h8000);
    send_sample(1'b1, KIND_AXIS, AXIS_NUM_LATERAL, 16'd1);
    send_sample(1'b1, KIND_AXIS, AXIS_NUM_LATERAL, 16'd131);   // just outside
    send_sample(1'b1, KIND_AXIS, AXIS_NUM_LATERAL, 16'hFF7E);  // just inside
    send_sample(1'b1, KIND_AXIS, AXIS_NUM_TURN, 16'h8000);
    send_sample(1'b1, KIND_AXIS, AXIS_NUM_VERTICAL, 16'h4000);
    send_sample(1'b1, KIND_AXIS, AXIS_NUM_TURN, 16'h0000);
    for (int n = 0; n <= BTN_NUM_LAST_PAD; n++)
      send_sample(1'b1, KIND_BUTTON, n[7:0], 16'h8000);
    send_sample(1'b1, KIND_BUTTON, BTN_NUM_SELECT, 16'd1);
    send_sample(1'b1, KIND_BUTTON, BTN_NUM_START, 16'hFFFF);
    send_sample(1'b1, KIND_BUTTON, BTN_NUM_UNMAPPED, 16'd1);
    send_sample(1'b1, KIND_BUTTON, 8'hFF, 16'd1);
    send_sample(1'b1, KIND_BUTTON, BTN_NUM_SELECT, 16'd0);     // stop stays set
    send_sample(1'b1, KIND_INIT_FLAG | KIND_BUTTON, BTN_NUM_CROSS, 16'd0);
    send_sample(1'b1, KIND_INIT_FLAG | KIND_AXIS, AXIS_NUM_FORWARD, 16'd0);
    send_sample(1'b1, 8'h00, AXIS_NUM_FORWARD, 16'd0);
    send_sample(1'b1, 8'hFF, BTN_NUM_CROSS, 16'd0);
  endtask

  // Walk through gain, weight and band settings, extremes included; the
  // sender pauses until the block is empty before each change.
  task automatic test_settings_sweep();
    for (int phase = 0; phase < 8; phase++) begin
      wait_drained();
      case (phase)
        0: apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, WEIGHT_UNITY, 16'd0);
        1: apply_settings(16'd4096, 16'd12000, 16'hFFFF, 17'd0, BAND_RESET);
        2: apply_settings(16'd0, 16'd0, 16'd0, WEIGHT_UNITY, 16'hFFFF);
        3: apply_settings(16'($urandom), 16'($urandom), 16'($urandom), 17'd1,
                          16'($urandom_range(0, 600)));
        4: apply_settings(16'd30000, 16'd20000, 16'd50000, 17'h1FFFF, 16'hFFFF);
        5: apply_settings(16'($urandom), 16'($urandom), 16'($urandom),
                          17'($urandom_range(0, UNITY)), 16'($urandom_range(0, 2000)));
        6: apply_settings(16'hFFFF, 16'd1, 16'd40000, 17'd32768, 16'd1);
        default: apply_settings(16'($urandom), 16'($urandom), 16'($urandom),
                                17'($urandom_range(0, 131071)),
                                16'($urandom_range(0, 4000)));
      endcase
      run_random(RANDOM_PER_PHASE);
    end
  endtask

  // Hold the receiver off while the sender keeps offering, so the result
  // register fills and the sample side has to stall.
  task automatic test_result_backpressure();
    steady    = 1'b1;
    sink_hold = HOLD_OFF_CYCLES;
    run_random(40);
    steady    = 1'b0;
  endtask

  task automatic test_steady_stream();
    steady = 1'b1;
    run_random(100);
    steady = 1'b0;
  endtask

  initial begin
    sample.valid          <= 1'b0;
    sample.event_present  <= 1'b0;
    sample.event_kind     <= '0;
    sample.control_number <= '0;
    sample.control_value  <= '0;
    cfg.valid             <= 1'b0;
    cfg.reg_index         <= REG_SCALE_FORWARD;
    cfg.data              <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_directed_events();
    test_settings_sweep();
    test_result_backpressure();
    test_steady_stream();

    wait_drained();
    if (!failed) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire

[gamepad_velocity_reference_core.f]
design/gvr_pkg.sv
design/gvr_if.sv
design/gvr_ctrl.sv
design/gvr_dp.sv
design/gamepad_velocity_reference_core.sv
design/gvr_checker.sv
verif/tb_top.sv
